// ----- hdl/bfa_pkg.sv -----
`default_nettype none

package bfa_pkg;

   // request operation codes
   localparam logic OP_ALLOC = 1'b0;
   localparam logic OP_FREE  = 1'b1;

   // response status codes
   localparam logic [1:0] ST_OK    = 2'd0;
   localparam logic [1:0] ST_BAD   = 2'd1;
   localparam logic [1:0] ST_NOFIT = 2'd2;

   typedef struct packed {
      logic        op;
      logic [11:0] req_bytes;
      logic [11:0] payload_addr;
   } req_type;

   typedef struct packed {
      logic [1:0]  status;
      logic [11:0] granted_addr;
   } rsp_type;

   // decoded flags of one boundary tag
   typedef struct packed {
      logic size_ok;
      logic busy;
      logic prev_busy;
   } tag_info_type;

endpackage

`default_nettype wire

// ----- hdl/bfa_tag_check.sv -----
`default_nettype none

module bfa_tag_check #(
   parameter  int HEAP_BYTES = 4096,
   localparam int HEAP_LEN   = (HEAP_BYTES / 4) * 4,
   localparam int PW         = $clog2(HEAP_LEN + 5)
) (
   input  logic [PW-1:0]         tag,
   input  logic [PW-1:0]         pos,
   output logic [PW-1:0]         size,
   output bfa_pkg::tag_info_type info
);
   import bfa_pkg::*;

   localparam logic [PW-1:0] LEN_P = PW'(HEAP_LEN);

   logic [PW-1:0] room;

   // strip flag bits, then check the block stays inside the heap
   assign size           = tag & ~PW'(3);
   assign room           = LEN_P - pos;
   assign info.size_ok   = (size >= PW'(4)) && (size <= room);
   assign info.busy      = tag[0];
   assign info.prev_busy = tag[1];

endmodule

`default_nettype wire

// ----- hdl/best_fit_block_allocator.sv -----
`default_nettype none

// Best-fit boundary-tag heap allocator. One request (allocate or free) is
// taken at a time; req_stall stays high until its response is built. An
// allocate walks every block of the heap, one block header per cycle from a
// single tag memory read port (at most HEAP_BYTES/8 blocks), then updates
// the tags of the best fit. A free walks the block list up to the target
// block, one block per cycle, then merges neighbors and writes tags. A
// request with a bad size or address skips the walk. After reset the tag
// memory is cleared before the first request is accepted. A finished
// response waits in an output register, so the next request is accepted
// while the previous response is still stalled.
module best_fit_block_allocator #(
   parameter  int HEAP_BYTES = 4096,
   localparam int HEAP_WORDS = HEAP_BYTES / 4,
   localparam int HEAP_LEN   = HEAP_WORDS * 4,
   localparam int PW         = $clog2(HEAP_LEN + 5),
   localparam int AW         = $clog2(HEAP_WORDS)
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  bfa_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output bfa_pkg::rsp_type rsp_data
);
   import bfa_pkg::*;

   localparam logic [PW-1:0] LEN_P    = PW'(HEAP_LEN);
   localparam logic [PW-1:0] FOUR     = PW'(4);
   localparam logic [PW-1:0] EIGHT    = PW'(8);
   localparam logic [PW-1:0] BUSY_BIT = PW'(1);
   localparam logic [PW-1:0] PREV_BIT = PW'(2);
   localparam logic [AW-1:0] LAST_IDX = AW'(HEAP_WORDS - 1);

   localparam logic [3:0] S_CLEAR    = 4'd0;
   localparam logic [3:0] S_IDLE     = 4'd1;
   localparam logic [3:0] S_WALK     = 4'd2;
   localparam logic [3:0] S_A_SPLIT1 = 4'd3;
   localparam logic [3:0] S_A_SPLIT2 = 4'd4;
   localparam logic [3:0] S_A_SPLIT3 = 4'd5;
   localparam logic [3:0] S_A_EXACT  = 4'd6;
   localparam logic [3:0] S_A_NXT    = 4'd7;
   localparam logic [3:0] S_F_NXT    = 4'd8;
   localparam logic [3:0] S_F_PRV    = 4'd9;
   localparam logic [3:0] S_F_PRV_EV = 4'd10;
   localparam logic [3:0] S_F_WR_HDR = 4'd11;
   localparam logic [3:0] S_F_WR_FT  = 4'd12;
   localparam logic [3:0] S_DONE     = 4'd13;

   function automatic logic [AW-1:0] word_idx(input logic [PW-1:0] p);
      word_idx = p[AW+1:2];
   endfunction

   // tag memory
   logic [PW-1:0] mem [HEAP_WORDS];
   logic [PW-1:0] rdata_ff;
   logic          wr_en, rd_en;
   logic [AW-1:0] wr_idx, rd_idx;
   logic [PW-1:0] wr_data;

   // sequencer registers
   logic [3:0]    state_ff, state_in;
   logic [AW-1:0] clr_cnt_ff, clr_cnt_in;
   logic          op_ff, op_in;
   logic [PW-1:0] need_ff, need_in;
   logic [PW-1:0] hdr_ff, hdr_in;
   logic [PW-1:0] pos_ff, pos_in;
   logic          found_ff, found_in;
   logic [PW-1:0] best_pos_ff, best_pos_in;
   logic [PW-1:0] best_sz_ff, best_sz_in;
   logic [PW-1:0] best_waste_ff, best_waste_in;
   logic          best_prev_ff, best_prev_in;
   logic [PW-1:0] total_ff, total_in;
   logic [PW-1:0] start_ff, start_in;
   logic [PW-1:0] foot_ff, foot_in;
   logic          hprev_ff, hprev_in;
   logic [1:0]    stat_ff, stat_in;
   logic [11:0]   grant_ff, grant_in;
   logic          rsp_valid_ff;
   rsp_type       rsp_data_ff;
   logic          load_rsp;

   // combinational helpers
   logic [PW-1:0] chk_size;
   tag_info_type  chk_info;
   logic [PW-1:0] walk_next;
   logic [PW-1:0] waste_new;
   logic [PW-1:0] need_new;
   logic [13:0]   req_round;
   logic          bad_size, bad_addr;
   logic [31:0]   grant_sum;
   logic [PW-1:0] best_end;
   logic [PW-1:0] prev_flag;

   bfa_tag_check #(.HEAP_BYTES(HEAP_BYTES)) u_tag_check (
      .tag  (rdata_ff),
      .pos  (pos_ff),
      .size (chk_size),
      .info (chk_info)
   );

   assign walk_next = pos_ff + chk_size;
   assign waste_new = chk_size - need_ff;
   assign req_round = (14'(req_data.req_bytes) + 14'd3) & ~14'd3;
   assign need_new  = PW'(req_round + 14'd4);
   assign bad_size  = (req_data.req_bytes == 12'd0)
                      || (32'(req_data.req_bytes) >= 32'(HEAP_LEN));
   assign bad_addr  = (req_data.payload_addr < 12'd4)
                      || (32'(req_data.payload_addr) >= 32'(HEAP_LEN))
                      || (req_data.payload_addr[1:0] != 2'b00);
   assign grant_sum = 32'(best_pos_ff) + 32'd4;
   assign best_end  = best_pos_ff + best_sz_ff;
   assign prev_flag = best_prev_ff ? PREV_BIT : '0;

   // memory: one write and one registered read per cycle
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_idx] <= wr_data;
      end
      if (rd_en) begin
         rdata_ff <= mem[rd_idx];
      end
   end

   // sequencer
   always_comb begin
      state_in      = state_ff;
      clr_cnt_in    = clr_cnt_ff;
      op_in         = op_ff;
      need_in       = need_ff;
      hdr_in        = hdr_ff;
      pos_in        = pos_ff;
      found_in      = found_ff;
      best_pos_in   = best_pos_ff;
      best_sz_in    = best_sz_ff;
      best_waste_in = best_waste_ff;
      best_prev_in  = best_prev_ff;
      total_in      = total_ff;
      start_in      = start_ff;
      foot_in       = foot_ff;
      hprev_in      = hprev_ff;
      stat_in       = stat_ff;
      grant_in      = grant_ff;
      wr_en         = 1'b0;
      wr_idx        = '0;
      wr_data       = '0;
      rd_en         = 1'b0;
      rd_idx        = '0;
      load_rsp      = 1'b0;

      unique case (state_ff)
         S_CLEAR: begin
            // sweep the heap back to one free block
            wr_en  = 1'b1;
            wr_idx = clr_cnt_ff;
            if (clr_cnt_ff == '0) begin
               wr_data = LEN_P | PREV_BIT;
            end else if (clr_cnt_ff == LAST_IDX) begin
               wr_data = LEN_P;
            end
            clr_cnt_in = clr_cnt_ff + AW'(1);
            if (clr_cnt_ff == LAST_IDX) begin
               state_in = S_IDLE;
            end
         end

         S_IDLE: begin
            if (req_valid) begin
               op_in    = req_data.op;
               need_in  = need_new;
               hdr_in   = PW'(req_data.payload_addr) - FOUR;
               found_in = 1'b0;
               pos_in   = '0;
               grant_in = '0;
               rd_en    = 1'b1;
               rd_idx   = '0;
               if (req_data.op == OP_ALLOC) begin
                  if (bad_size) begin
                     stat_in  = ST_BAD;
                     state_in = S_DONE;
                  end else begin
                     state_in = S_WALK;
                  end
               end else begin
                  if (bad_addr) begin
                     stat_in  = ST_BAD;
                     state_in = S_DONE;
                  end else begin
                     state_in = S_WALK;
                  end
               end
            end
         end

         S_WALK: begin
            if (op_ff == OP_ALLOC) begin
               if (pos_ff >= LEN_P || !chk_info.size_ok) begin
                  // end of heap: commit the best fit, or answer no-fit
                  if (!found_ff) begin
                     stat_in  = ST_NOFIT;
                     state_in = S_DONE;
                  end else begin
                     stat_in  = ST_OK;
                     grant_in = grant_sum[11:0];
                     state_in = (best_waste_ff >= EIGHT) ? S_A_SPLIT1 : S_A_EXACT;
                  end
               end else begin
                  if (!chk_info.busy && chk_size >= need_ff
                      && (!found_ff || waste_new < best_waste_ff)) begin
                     found_in      = 1'b1;
                     best_waste_in = waste_new;
                     best_pos_in   = pos_ff;
                     best_sz_in    = chk_size;
                     best_prev_in  = chk_info.prev_busy;
                  end
                  pos_in = walk_next;
                  rd_en  = 1'b1;
                  rd_idx = (walk_next < LEN_P) ? word_idx(walk_next) : '0;
               end
            end else begin
               if (pos_ff >= LEN_P || pos_ff > hdr_ff || !chk_info.size_ok) begin
                  stat_in  = ST_BAD;
                  state_in = S_DONE;
               end else if (pos_ff == hdr_ff) begin
                  if (!chk_info.busy) begin
                     stat_in  = ST_BAD;
                     state_in = S_DONE;
                  end else begin
                     total_in = chk_size;
                     start_in = hdr_ff;
                     foot_in  = walk_next - FOUR;
                     hprev_in = chk_info.prev_busy;
                     pos_in   = walk_next;
                     if (walk_next < LEN_P) begin
                        rd_en    = 1'b1;
                        rd_idx   = word_idx(walk_next);
                        state_in = S_F_NXT;
                     end else begin
                        state_in = S_F_PRV;
                     end
                  end
               end else begin
                  pos_in = walk_next;
                  rd_en  = 1'b1;
                  rd_idx = (walk_next < LEN_P) ? word_idx(walk_next) : '0;
               end
            end
         end

         S_A_SPLIT1: begin
            wr_en    = 1'b1;
            wr_idx   = word_idx(best_pos_ff);
            wr_data  = need_ff | BUSY_BIT | prev_flag;
            state_in = S_A_SPLIT2;
         end

         S_A_SPLIT2: begin
            wr_en    = 1'b1;
            wr_idx   = word_idx(best_pos_ff + need_ff);
            wr_data  = best_waste_ff | PREV_BIT;
            state_in = S_A_SPLIT3;
         end

         S_A_SPLIT3: begin
            wr_en    = 1'b1;
            wr_idx   = word_idx(best_end - FOUR);
            wr_data  = best_waste_ff;
            state_in = S_DONE;
         end

         S_A_EXACT: begin
            // absorb slack, then mark the next block's previous-busy bit
            wr_en   = 1'b1;
            wr_idx  = word_idx(best_pos_ff);
            wr_data = best_sz_ff | BUSY_BIT | prev_flag;
            if (best_end < LEN_P) begin
               rd_en    = 1'b1;
               rd_idx   = word_idx(best_end);
               pos_in   = best_end;
               state_in = S_A_NXT;
            end else begin
               state_in = S_DONE;
            end
         end

         S_A_NXT: begin
            wr_en    = 1'b1;
            wr_idx   = word_idx(pos_ff);
            wr_data  = rdata_ff | PREV_BIT;
            state_in = S_DONE;
         end

         S_F_NXT: begin
            // merge with a free successor or clear its previous-busy bit
            if (!chk_info.busy && chk_info.size_ok) begin
               total_in = total_ff + chk_size;
               foot_in  = walk_next - FOUR;
            end else begin
               wr_en   = 1'b1;
               wr_idx  = word_idx(pos_ff);
               wr_data = rdata_ff & ~PREV_BIT;
            end
            state_in = S_F_PRV;
         end

         S_F_PRV: begin
            if (!hprev_ff && hdr_ff >= FOUR) begin
               rd_en    = 1'b1;
               rd_idx   = word_idx(hdr_ff - FOUR);
               state_in = S_F_PRV_EV;
            end else begin
               state_in = S_F_WR_HDR;
            end
         end

         S_F_PRV_EV: begin
            // chk_size here is the predecessor footer size
            if (chk_size >= FOUR && chk_size <= hdr_ff) begin
               total_in = total_ff + chk_size;
               start_in = hdr_ff - chk_size;
            end
            state_in = S_F_WR_HDR;
         end

         S_F_WR_HDR: begin
            wr_en    = 1'b1;
            wr_idx   = word_idx(start_ff);
            wr_data  = total_ff | PREV_BIT;
            state_in = S_F_WR_FT;
         end

         S_F_WR_FT: begin
            wr_en    = 1'b1;
            wr_idx   = word_idx(foot_ff);
            wr_data  = total_ff;
            stat_in  = ST_OK;
            grant_in = '0;
            state_in = S_DONE;
         end

         S_DONE: begin
            // hand the response to the output register once it is free
            if (!rsp_valid_ff || !rsp_stall) begin
               load_rsp = 1'b1;
               state_in = S_IDLE;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= S_CLEAR;
         clr_cnt_ff <= '0;
      end else begin
         state_ff   <= state_in;
         clr_cnt_ff <= clr_cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff         <= op_in;
      need_ff       <= need_in;
      hdr_ff        <= hdr_in;
      pos_ff        <= pos_in;
      found_ff      <= found_in;
      best_pos_ff   <= best_pos_in;
      best_sz_ff    <= best_sz_in;
      best_waste_ff <= best_waste_in;
      best_prev_ff  <= best_prev_in;
      total_ff      <= total_in;
      start_ff      <= start_in;
      foot_ff       <= foot_in;
      hprev_ff      <= hprev_in;
      stat_ff       <= stat_in;
      grant_ff      <= grant_in;
   end

   // output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (load_rsp) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (load_rsp) begin
         rsp_data_ff.status       <= stat_ff;
         rsp_data_ff.granted_addr <= grant_ff;
      end
   end

   assign req_stall = (state_ff != S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

`ifndef SYNTHESIS
   a_idle_no_write: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_IDLE) |-> !wr_en)
      else $error("tag write while idle");

   a_accept_leaves_idle: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> (state_ff != S_IDLE))
      else $error("accepted request did not start");

   a_taken_empties: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_stall && state_ff != S_DONE) |=> !rsp_valid_ff)
      else $error("response repeated");

   a_fail_no_grant: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.status != ST_OK) |-> (rsp_data.granted_addr == 12'd0))
      else $error("grant on failed request");
`endif

endmodule

`default_nettype wire

// ----- tb/best_fit_block_allocator_tb.sv -----
`default_nettype none

module best_fit_block_allocator_tb;
   import bfa_pkg::*;

   localparam int unsigned HEAP_LEN   = 4096;
   localparam int unsigned HEAP_WORDS = HEAP_LEN / 4;
   localparam int unsigned SIZE_MASK  = 32'hFFFF_FFFC;
   localparam int unsigned MIN_SPLIT  = 8;
   localparam int unsigned TAG_BYTES  = 4;
   localparam int unsigned CYCLE_LIMIT = 4_000_000;
   localparam int unsigned DRAIN_CYCLES = 40;

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_stall;
   req_type req_data = '0;
   logic    rsp_valid;
   logic    rsp_stall = 1'b0;
   rsp_type rsp_data;

   // shadow heap and live payload offsets
   logic [31:0] shadow_tags [HEAP_WORDS];
   int unsigned live_grants [$];
   rsp_type     predicted_rsps [$];

   int unsigned tx_idle_pct = 0;
   int unsigned rx_idle_pct = 0;
   bit          rsp_hold = 1'b0;
   int unsigned hold_left = 0;
   int unsigned cycle_count = 0;
   int unsigned mismatch_count = 0;
   int unsigned rsp_count = 0;
   int unsigned n_alloc_ok = 0, n_free_ok = 0, n_nofit = 0, n_bad = 0;

   best_fit_block_allocator DUT (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   always #2 clock = ~clock;

   // count cycles and abort a hung run
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d responses outstanding",
                  cycle_count, predicted_rsps.size());
         $display("[FAIL] regression broken");
         $finish;
      end
   end

   // drive response stall: long hold-off when asked, else random idling
   always @(posedge clock) begin
      if (rsp_hold) begin
         rsp_stall <= 1'b1;
         if (hold_left > 0) hold_left <= hold_left - 1;
         else rsp_hold <= 1'b0;
      end else begin
         rsp_stall <= ($urandom_range(99) < rx_idle_pct);
      end
   end

   // check each accepted response against the oldest prediction
   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         rsp_count++;
         if (predicted_rsps.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= 10)
               $display("unexpected response status=%0d addr=%0d",
                        rsp_data.status, rsp_data.granted_addr);
         end else begin
            want = predicted_rsps.pop_front();
            if (rsp_data.status !== want.status ||
                rsp_data.granted_addr !== want.granted_addr) begin
               mismatch_count++;
               if (mismatch_count <= 10)
                  $display("mismatch: expected status=%0d addr=%0d, got status=%0d addr=%0d",
                           want.status, want.granted_addr,
                           rsp_data.status, rsp_data.granted_addr);
            end
         end
      end
   end

   function automatic int unsigned tag_rd(int unsigned pos);
      if (pos >= HEAP_LEN) return 0;
      return shadow_tags[pos >> 2];
   endfunction

   function automatic void tag_wr(int unsigned pos, int unsigned v);
      if (pos < HEAP_LEN) shadow_tags[pos >> 2] = v;
   endfunction

   function automatic int unsigned block_len(int unsigned pos);
      int unsigned sz;
      sz = tag_rd(pos) & SIZE_MASK;
      if (sz < TAG_BYTES || sz > HEAP_LEN - pos) return 0;
      return sz;
   endfunction

   function automatic void heap_clear();
      foreach (shadow_tags[i]) shadow_tags[i] = '0;
      tag_wr(0, HEAP_LEN + 2);
      tag_wr(HEAP_LEN - TAG_BYTES, HEAP_LEN);
   endfunction

   // best-fit allocate on the shadow heap
   function automatic rsp_type heap_alloc(int unsigned nbytes);
      rsp_type r;
      int unsigned need, pos, sz, waste, best_pos, best_sz, best_waste, prev, nxt;
      bit found;
      r = '0;
      found = 1'b0;
      best_pos = 0; best_sz = 0; best_waste = 0;
      if (nbytes == 0 || nbytes >= HEAP_LEN) begin
         r.status = ST_BAD;
         return r;
      end
      need = ((nbytes + 3) & SIZE_MASK) + TAG_BYTES;
      pos = 0;
      while (pos < HEAP_LEN) begin
         sz = block_len(pos);
         if (sz == 0) break;
         if ((tag_rd(pos) & 1) == 0 && sz >= need) begin
            waste = sz - need;
            if (!found || waste < best_waste) begin
               found = 1'b1;
               best_waste = waste;
               best_pos = pos;
               best_sz = sz;
            end
         end
         pos += sz;
      end
      if (!found) begin
         r.status = ST_NOFIT;
         return r;
      end
      prev = tag_rd(best_pos) & 2;
      if (best_waste >= MIN_SPLIT) begin
         tag_wr(best_pos, need | 1 | prev);
         tag_wr(best_pos + need, best_waste | 2);
         tag_wr(best_pos + best_sz - TAG_BYTES, best_waste);
      end else begin
         nxt = best_pos + best_sz;
         tag_wr(best_pos, best_sz | 1 | prev);
         if (nxt < HEAP_LEN) tag_wr(nxt, tag_rd(nxt) | 2);
      end
      r.status = ST_OK;
      r.granted_addr = 12'(best_pos + TAG_BYTES);
      return r;
   endfunction

   // free with neighbor merge on the shadow heap
   function automatic rsp_type heap_free(int unsigned addr);
      rsp_type r;
      int unsigned hdr, pos, s, sz, total, start, foot, nxt, htag, ntag, nsz, psz;
      bit hit;
      r = '0;
      r.status = ST_BAD;
      hit = 1'b0;
      if (addr < TAG_BYTES || addr >= HEAP_LEN || (addr & 3) != 0) return r;
      hdr = addr - TAG_BYTES;
      pos = 0;
      while (pos < HEAP_LEN && pos <= hdr) begin
         s = block_len(pos);
         if (s == 0) break;
         if (pos == hdr) begin
            hit = 1'b1;
            break;
         end
         pos += s;
      end
      if (!hit) return r;
      htag = tag_rd(hdr);
      if ((htag & 1) == 0) return r;
      sz = block_len(hdr);
      total = sz;
      start = hdr;
      foot = hdr + sz - TAG_BYTES;
      nxt = hdr + sz;
      if (nxt < HEAP_LEN) begin
         ntag = tag_rd(nxt);
         nsz = block_len(nxt);
         if ((ntag & 1) == 0 && nsz != 0) begin
            total += nsz;
            foot = nxt + nsz - TAG_BYTES;
         end else begin
            tag_wr(nxt, ntag & ~32'd2);
         end
      end
      if ((htag & 2) == 0 && hdr >= TAG_BYTES) begin
         psz = tag_rd(hdr - TAG_BYTES) & SIZE_MASK;
         if (psz >= TAG_BYTES && psz <= hdr) begin
            total += psz;
            start = hdr - psz;
         end
      end
      tag_wr(start, total | 2);
      tag_wr(foot, total);
      r.status = ST_OK;
      return r;
   endfunction

   // predict one request, track live grants, then hand it to the block
   task automatic send_request(logic op, int unsigned nbytes, int unsigned addr);
      req_type req;
      rsp_type r;
      int idx [$];
      req.op = op;
      req.req_bytes = 12'(nbytes);
      req.payload_addr = 12'(addr);
      if (op == OP_ALLOC) r = heap_alloc(req.req_bytes);
      else r = heap_free(req.payload_addr);
      case (r.status)
         ST_OK: begin
            if (op == OP_ALLOC) begin
               n_alloc_ok++;
               live_grants.push_back(r.granted_addr);
            end else begin
               n_free_ok++;
               idx = live_grants.find_first_index(x) with (x == req.payload_addr);
               if (idx.size() > 0) live_grants.delete(idx[0]);
            end
         end
         ST_NOFIT: n_nofit++;
         default:  n_bad++;
      endcase
      predicted_rsps.push_back(r);
      // random sender gap
      while ($urandom_range(99) < tx_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data <= req;
      @(posedge clock);
      while (req_stall) @(posedge clock);
   endtask

   task automatic wait_drained();
      req_valid <= 1'b0;
      while (predicted_rsps.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic test_directed();
      int unsigned a, b, c;
      // size checks and full-heap exact fit
      send_request(OP_ALLOC, 0, 0);
      send_request(OP_ALLOC, 4095, 0);
      send_request(OP_ALLOC, 4092, 0);
      send_request(OP_ALLOC, 1, 0);
      send_request(OP_FREE, 0, 4);
      send_request(OP_FREE, 0, 4);
      // bad free addresses
      send_request(OP_FREE, 4095, 0);
      send_request(OP_FREE, 0, 2);
      send_request(OP_FREE, 0, 4095);
      send_request(OP_FREE, 0, 4092);
      // split, near fit and merges on both sides
      send_request(OP_ALLOC, 1, 0);
      a = live_grants[$];
      send_request(OP_ALLOC, 10, 0);
      b = live_grants[$];
      send_request(OP_ALLOC, 3000, 0);
      c = live_grants[$];
      send_request(OP_ALLOC, 2000, 0);
      send_request(OP_FREE, 0, a);
      send_request(OP_FREE, 0, c);
      send_request(OP_FREE, 0, b);
      send_request(OP_ALLOC, 4080, 0);
      send_request(OP_ALLOC, 8, 0);
      send_request(OP_ALLOC, 4, 0);
      send_request(OP_FREE, 0, 12);
      while (live_grants.size() > 0) send_request(OP_FREE, 0, live_grants[0]);
      wait_drained();
   endtask

   // mostly well-formed churn, some noise frees and large sizes
   task automatic random_request();
      int unsigned pick, k;
      pick = $urandom_range(99);
      if (pick < 48) begin
         if ($urandom_range(9) == 0) send_request(OP_ALLOC, $urandom_range(4095), $urandom);
         else send_request(OP_ALLOC, $urandom_range(1, 120), $urandom);
      end else if (pick < 88 && live_grants.size() > 0) begin
         k = $urandom_range(live_grants.size() - 1);
         send_request(OP_FREE, $urandom, live_grants[k]);
      end else begin
         send_request(OP_FREE, $urandom, $urandom_range(4095));
      end
   endtask

   task automatic test_random_idling();
      tx_idle_pct = 10; rx_idle_pct = 67;
      repeat (240) random_request();
      tx_idle_pct = 67; rx_idle_pct = 10;
      repeat (240) random_request();
      tx_idle_pct = 0; rx_idle_pct = 0;
      repeat (240) random_request();
      wait_drained();
   endtask

   task automatic test_backpressure();
      tx_idle_pct = 0; rx_idle_pct = 0;
      hold_left = 2000;
      rsp_hold = 1'b1;
      repeat (30) send_request(OP_ALLOC, $urandom_range(1, 16), 0);
      wait_drained();
   endtask

   initial begin
      heap_clear();
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      test_directed();
      test_backpressure();
      test_random_idling();
      $display("covered %0d responses: %0d allocs granted, %0d frees done,",
               rsp_count, n_alloc_ok, n_free_ok);
      $display("  %0d rejected and %0d no-fit requests, with idling and a long stall",
               n_bad, n_nofit);
      if (mismatch_count == 0 && predicted_rsps.size() == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("%0d mismatches, %0d responses missing",
                  mismatch_count, predicted_rsps.size());
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule

`default_nettype wire
